FILE: hdl/afir_pkg.sv
`default_nettype none

package afir_pkg;

    // sample and coefficient format, signed Q1.15
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    // saturated magnitude, Q0.15
    localparam int MAG_W     = 15;
    // one product of coefficient and magnitude, and the full sum of four
    localparam int PROD_W    = 31;
    localparam int ACC_W     = 33;

    // coefficient register file
    localparam int COEF_NUM   = 4;
    localparam int COEF_IDX_W = 2;
    localparam int CFG_IDX_W  = 8;

    // window fill counter, saturates at three held samples
    localparam int FILL_W   = 2;
    localparam int FILL_MAX = 3;

    // default and upper bound of the tap count
    localparam int TAPS_DEF = 4;
    localparam int TAPS_MAX = 4;

    // stream word widths, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic        [MAG_W-1:0]  mag_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic        [FILL_W-1:0] fill_t;

    // magnitude of a Q1.15 sample, the most negative code saturates
    function automatic mag_t sat_abs(input logic signed [SAMPLE_W-1:0] x);
        logic [SAMPLE_W-1:0] m;
        m = x[SAMPLE_W-1] ? SAMPLE_W'(-x) : x;
        if (m[SAMPLE_W-1]) begin
            sat_abs = {MAG_W{1'b1}};
        end else begin
            sat_abs = m[MAG_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/abs_fir_filter_4tap_top.sv
// channel   dir  ports                          word
// s_        in   s_tvalid s_tready s_tdata      sample[15:0]; tuser frame_first,
//                s_tuser s_tlast                tlast frame_last
// m_        out  m_tvalid m_tready m_tdata      filtered[32:0], zeros [39:33];
//                m_tlast                        tlast end_of_frame
// cfg_      in   cfg_valid cfg_ready            cfg_index register number,
//                cfg_index cfg_data             cfg_data coefficient
//
// one sample per clock while s_tready is high, result valid on m_ once it has passed every stage
// the stages are window register, product register, sum/output register
// samples that fill the window advance history and fill count but make no result
// s_tready drops only while every stage holds a word and m_tready is low
// aresetn clears history, fill count, coefficients and all stage valids
`default_nettype none

module abs_fir_filter_4tap_top
    import afir_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    // input stream
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [S_TDATA_W-1:0]   s_tdata,   // [15:0] sample
    input  wire                    s_tuser,   // [0] frame_first
    input  wire                    s_tlast,
    // result stream
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [32:0] filtered, [39:33] zero
    output logic                   m_tlast,
    // coefficient writes
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   cfg_index,
    input  wire  [COEF_W-1:0]      cfg_data
);

    localparam int HIST_D = (TAPS > 1) ? TAPS - 1 : 1;

    // coefficients and sample history
    coef_t coef_reg [COEF_NUM];
    mag_t  hist_reg [HIST_D];
    fill_t fill_reg;
    fill_t fill_eff;
    fill_t fill_next;

    // pipeline registers
    logic  a_valid_reg;
    mag_t  a_win_reg [TAPS];
    logic  a_last_reg;
    logic  b_valid_reg;
    prod_t b_prod_reg [TAPS];
    logic  b_last_reg;
    logic  o_valid_reg;
    acc_t  o_sum_reg;
    logic  o_last_reg;

    logic  s_accept;
    logic  fire;
    mag_t  cur_mag;
    logic  o_ready;
    logic  b_move;
    logic  a_move;
    acc_t  sum_next;

    // flow control, each stage moves when the one after it has room
    assign o_ready  = !o_valid_reg || m_tready;
    assign b_move   = !b_valid_reg || o_ready;
    assign a_move   = !a_valid_reg || b_move;
    assign s_tready = a_move;
    assign s_accept = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    // coefficient register file, writes past the last register are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < COEF_NUM; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_valid && (cfg_index < CFG_IDX_W'(COEF_NUM))) begin
            coef_reg[cfg_index[COEF_IDX_W-1:0]] <= cfg_data;
        end
    end

    // window fill, first flag restarts it, last flag ends the frame
    assign cur_mag  = sat_abs(s_tdata[SAMPLE_W-1:0]);
    assign fill_eff = s_tuser ? '0 : fill_reg;
    assign fire     = (fill_eff >= FILL_W'(TAPS - 1));

    always_comb begin
        if (s_tlast) begin
            fill_next = '0;
        end else if (fill_eff < FILL_W'(FILL_MAX)) begin
            fill_next = fill_eff + FILL_W'(1);
        end else begin
            fill_next = fill_eff;
        end
    end

    // history shift and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            for (int i = 0; i < HIST_D; i++) begin
                hist_reg[i] <= '0;
            end
        end else if (s_accept) begin
            fill_reg    <= fill_next;
            hist_reg[0] <= cur_mag;
            for (int i = 1; i < HIST_D; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // window stage, only words that make a result enter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_move) begin
            a_valid_reg <= s_accept && fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_move) begin
            a_win_reg[0] <= cur_mag;
            for (int k = 1; k < TAPS; k++) begin
                a_win_reg[k] <= hist_reg[k-1];
            end
            a_last_reg <= s_tlast;
        end
    end

    // product stage, one multiplier per tap
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_move) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_move) begin
            for (int k = 0; k < TAPS; k++) begin
                b_prod_reg[k] <= prod_t'(coef_reg[k]) *
                                 prod_t'($signed({1'b0, a_win_reg[k]}));
            end
            b_last_reg <= a_last_reg;
        end
    end

    // sum of the products
    always_comb begin
        sum_next = '0;
        for (int k = 0; k < TAPS; k++) begin
            sum_next = sum_next + ACC_W'(b_prod_reg[k]);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (o_ready) begin
            o_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_ready) begin
            o_sum_reg  <= sum_next;
            o_last_reg <= b_last_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-ACC_W){1'b0}}, o_sum_reg};
    assign m_tlast  = o_last_reg;

endmodule

`default_nettype wire

FILE: hdl/afir_checker.sv
`default_nettype none

module afir_checker
    import afir_pkg::*;
(
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  s_tready,
    input wire                  m_tvalid,
    input wire                  m_tready,
    input wire [M_TDATA_W-1:0]  m_tdata,
    input wire                  m_tlast,
    input wire                  cfg_valid,
    input wire                  cfg_ready
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds its word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // an empty output register means the pipeline can take a word
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // the sum never reaches the padding bits
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:ACC_W] == '0))
        else $error("padding bits of result set");

    // coefficient writes never wait
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("coefficient write stalled");

endmodule

bind abs_fir_filter_4tap_top afir_checker u_afir_checker (.*);

`default_nettype wire
